/* rtl/utf8_stream_decoder_top_macros.svh */
// assertion macros shared by the checker of the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define U8SD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 stream decoder check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define U8SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 stream decoder check failed");

`endif

/* rtl/u8sd_pkg.sv */
// types and constants of the utf8 stream decoder
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPL_CP = 21'h00FFFD;

  // byte classes: mask and tag
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] ASCII_TAG  = 8'h00;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // payload bits kept from each byte kind
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  // what one accepted item leaves for the output side
  typedef struct packed {
    logic [1:0]     repl_cnt;   // leading replacement beats, 0..3
    logic           tail_vld;   // one more beat after them
    logic [CpW-1:0] tail_cp;
    logic           tail_repl;
  } run_t;

endpackage

`default_nettype wire

/* rtl/u8sd_stream_if.sv */
// valid/ready channel interfaces of the utf8 stream decoder
`default_nettype none

interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8sd_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8sd_pkg::CpW-1:0]  code_point;
  logic                      is_replacement;
  logic                      last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/u8sd_decode.sv */
// sequence state and per-byte decode into a run of result beats
`default_nettype none

module u8sd_decode (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic [7:0]     in_byte,
  input  wire logic           end_of_text,
  output u8sd_pkg::run_t      run
);

  logic [u8sd_pkg::CpW-1:0] pv_r, pv_nxt;
  logic [1:0]               exp_r, exp_nxt;
  logic [1:0]               tkn_r, tkn_nxt;

  logic                     pending;
  logic                     is_cont;
  logic                     cont_take;
  logic                     flush;
  logic                     fresh;
  logic [1:0]               tkn_clip;
  logic [u8sd_pkg::CpW-1:0] shifted;

  // byte classification and the three paths of one item
  always_comb begin
    pending   = (exp_r != 2'd0);
    is_cont   = ((in_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG);
    cont_take = !end_of_text && pending && is_cont;
    flush     = pending && (end_of_text || !is_cont);
    fresh     = !end_of_text && !cont_take;
    tkn_clip  = (tkn_r == 2'd3) ? 2'd2 : tkn_r;
    shifted   = {pv_r[u8sd_pkg::CpW-7:0], in_byte[5:0]};
  end

  // next state and the run of beats for this item
  always_comb begin
    pv_nxt  = pv_r;
    exp_nxt = exp_r;
    tkn_nxt = tkn_r;
    run     = '0;

    // missing continuation or end of text: one beat for the lead, one per continuation
    if (flush) begin
      run.repl_cnt = tkn_clip + 2'd1;
      pv_nxt       = '0;
      exp_nxt      = 2'd0;
      tkn_nxt      = 2'd0;
    end

    // continuation gathers six bits
    if (cont_take) begin
      if (exp_r == 2'd1) begin
        run.tail_vld  = 1'b1;
        run.tail_cp   = shifted;
        run.tail_repl = 1'b0;
        pv_nxt        = '0;
        exp_nxt       = 2'd0;
        tkn_nxt       = 2'd0;
      end else begin
        pv_nxt  = shifted;
        exp_nxt = exp_r - 2'd1;
        tkn_nxt = tkn_r + 2'd1;
      end
    end

    // byte handled as if nothing were pending
    if (fresh) begin
      if ((in_byte & u8sd_pkg::ASCII_MASK) == u8sd_pkg::ASCII_TAG) begin
        run.tail_vld  = 1'b1;
        run.tail_cp   = {{(u8sd_pkg::CpW-8){1'b0}}, in_byte};
        run.tail_repl = 1'b0;
      end else if ((in_byte & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_TAG) begin
        pv_nxt  = {{(u8sd_pkg::CpW-8){1'b0}}, in_byte & u8sd_pkg::LEAD2_BITS};
        exp_nxt = 2'd1;
        tkn_nxt = 2'd0;
      end else if ((in_byte & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_TAG) begin
        pv_nxt  = {{(u8sd_pkg::CpW-8){1'b0}}, in_byte & u8sd_pkg::LEAD3_BITS};
        exp_nxt = 2'd2;
        tkn_nxt = 2'd0;
      end else if ((in_byte & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_TAG) begin
        pv_nxt  = {{(u8sd_pkg::CpW-8){1'b0}}, in_byte & u8sd_pkg::LEAD4_BITS};
        exp_nxt = 2'd3;
        tkn_nxt = 2'd0;
      end else begin
        // stray continuation or invalid lead
        run.tail_vld  = 1'b1;
        run.tail_cp   = u8sd_pkg::REPL_CP;
        run.tail_repl = 1'b1;
      end
    end
  end

  // sequence state, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      exp_r <= 2'd0;
      tkn_r <= 2'd0;
    end else if (acc) begin
      pv_r  <= pv_nxt;
      exp_r <= exp_nxt;
      tkn_r <= tkn_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/u8sd_emit.sv */
// result register that plays out a run of beats, one per cycle while out_ready is high
`default_nettype none

module u8sd_emit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire u8sd_pkg::run_t            run,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [u8sd_pkg::CpW-1:0]       out_cp,
  output logic                           out_repl,
  output logic                           out_last
);

  logic [1:0]               cnt_r, cnt_nxt;
  logic                     tv_r, tv_nxt;
  logic [u8sd_pkg::CpW-1:0] tcp_r, tcp_nxt;
  logic                     trep_r, trep_nxt;

  // current beat: replacements first, then the tail
  always_comb begin
    out_valid = (cnt_r != 2'd0) || tv_r;
    if (cnt_r != 2'd0) begin
      out_cp   = u8sd_pkg::REPL_CP;
      out_repl = 1'b1;
      out_last = (cnt_r == 2'd1) && !tv_r;
    end else begin
      out_cp   = tcp_r;
      out_repl = trep_r;
      out_last = 1'b1;
    end
  end

  // load a new run or step the current one
  always_comb begin
    cnt_nxt  = cnt_r;
    tv_nxt   = tv_r;
    tcp_nxt  = tcp_r;
    trep_nxt = trep_r;
    if (load) begin
      cnt_nxt  = run.repl_cnt;
      tv_nxt   = run.tail_vld;
      tcp_nxt  = run.tail_cp;
      trep_nxt = run.tail_repl;
    end else if (out_valid && out_ready) begin
      if (cnt_r != 2'd0) begin
        cnt_nxt = cnt_r - 2'd1;
      end else begin
        tv_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      tv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tv_r  <= tv_nxt;
    end
    tcp_r  <= tcp_nxt;
    trep_r <= trep_nxt;
  end

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder_top.sv */
// Streaming UTF-8 decoder: takes byte beats and gives Unicode code points, with U+FFFD
// replacement for malformed input (missing continuation, stray continuation, bytes F8-FF,
// unfinished sequence at end of text). An item with at most one result does not hold the
// input while out_ready is high, so plain text flows at one byte per clock. An item with
// more results (up to 4) holds the input until its run has left, since the single result
// register plays out one beat per cycle while out_ready is high; the next byte is taken
// in the same cycle as the last beat of the run. The last_of_run flag marks the final beat
// caused by an input item. No overlong, surrogate or range checks are made.
`default_nettype none

module utf8_stream_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  u8sd_in_if.sink         in_ch,
  u8sd_out_if.source      out_ch
);

  u8sd_pkg::run_t run;
  logic           acc;
  logic           o_valid;
  logic           o_last;

  // take a new beat when the result register is empty or finishing its run
  assign in_ch.ready = !o_valid || (out_ch.ready && o_last);
  assign acc         = in_ch.valid && in_ch.ready;

  u8sd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .run         (run)
  );

  u8sd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .run       (run),
    .out_ready (out_ch.ready),
    .out_valid (o_valid),
    .out_cp    (out_ch.code_point),
    .out_repl  (out_ch.is_replacement),
    .out_last  (o_last)
  );

  assign out_ch.valid       = o_valid;
  assign out_ch.last_of_run = o_last;

endmodule

`default_nettype wire

/* rtl/u8sd_checker.sv */
// port-level checks of the utf8 stream decoder, bound to the top level
`default_nettype none

`include "utf8_stream_decoder_top_macros.svh"

module u8sd_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [u8sd_pkg::CpW-1:0] code_point,
  input wire logic                     is_replacement,
  input wire logic                     last_of_run
);

  // a stalled result beat stays offered
  `U8SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an empty result side always takes input
  `U8SD_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // with a beat offered, input is only taken while the last beat of a run leaves
  `U8SD_ASSERT_SAME(a_ready_on_last, in_ready && out_valid, out_ready && last_of_run)

  // only replacement beats precede the last one, and they carry U+FFFD
  `U8SD_ASSERT_SAME(a_early_is_repl, out_valid && (!last_of_run || is_replacement),
                    is_replacement && (code_point == u8sd_pkg::REPL_CP))

endmodule

bind utf8_stream_decoder_top u8sd_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .code_point     (out_ch.code_point),
  .is_replacement (out_ch.is_replacement),
  .last_of_run    (out_ch.last_of_run)
);

`default_nettype wire

/* tb/u8sd_tb_pkg.sv */
// scoreboard of the utf8 stream decoder testbench: decode prediction and result checks
package u8sd_tb_pkg;
  import u8sd_pkg::*;

  // one expected result beat
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_replacement;
    logic           last_of_run;
  } cp_beat_t;

  class code_point_scoreboard;
    logic [CpW-1:0] gathered;     // payload bits collected so far
    logic [1:0]     conts_left;   // continuations still missing
    logic [1:0]     conts_taken;  // continuations already collected
    cp_beat_t       expected_cps[$];
    cp_beat_t       run_cps[$];
    int unsigned    errors;

    function new();
      gathered    = '0;
      conts_left  = '0;
      conts_taken = '0;
      errors      = 0;
    endfunction

    function void add_beat(logic [CpW-1:0] cp, logic repl);
      cp_beat_t beat;
      beat.code_point     = cp;
      beat.is_replacement = repl;
      beat.last_of_run    = 1'b0;
      run_cps.push_back(beat);
    endfunction

    // one replacement for the lead plus one per continuation taken
    function void flush_pending();
      if (conts_left == 2'd0) return;
      add_beat(REPL_CP, 1'b1);
      for (int i = 0; i < conts_taken; i++) add_beat(REPL_CP, 1'b1);
      gathered    = '0;
      conts_left  = '0;
      conts_taken = '0;
    endfunction

    // byte seen with nothing pending
    function void decode_fresh(logic [7:0] byte_in);
      if ((byte_in & ASCII_MASK) == ASCII_TAG) begin
        add_beat(CpW'(byte_in), 1'b0);
      end else if ((byte_in & LEAD2_MASK) == LEAD2_TAG) begin
        gathered    = CpW'(byte_in & LEAD2_BITS);
        conts_left  = 2'd1;
        conts_taken = 2'd0;
      end else if ((byte_in & LEAD3_MASK) == LEAD3_TAG) begin
        gathered    = CpW'(byte_in & LEAD3_BITS);
        conts_left  = 2'd2;
        conts_taken = 2'd0;
      end else if ((byte_in & LEAD4_MASK) == LEAD4_TAG) begin
        gathered    = CpW'(byte_in & LEAD4_BITS);
        conts_left  = 2'd3;
        conts_taken = 2'd0;
      end else begin
        // stray continuation or invalid lead
        add_beat(REPL_CP, 1'b1);
      end
    endfunction

    // predict the results of one accepted input beat
    function void note_item(logic [7:0] byte_in, logic eot);
      cp_beat_t beat;
      run_cps.delete();
      if (eot) begin
        flush_pending();
      end else if (conts_left != 2'd0) begin
        if ((byte_in & CONT_MASK) == CONT_TAG) begin
          gathered   = (gathered << 6) | CpW'(byte_in & CONT_BITS);
          conts_left = conts_left - 2'd1;
          if (conts_left == 2'd0) begin
            add_beat(gathered, 1'b0);
            gathered    = '0;
            conts_taken = '0;
          end else begin
            conts_taken = conts_taken + 2'd1;
          end
        end else begin
          flush_pending();
          decode_fresh(byte_in);
        end
      end else begin
        decode_fresh(byte_in);
      end
      // mark the final beat of this run
      if (run_cps.size() != 0) begin
        beat = run_cps.pop_back();
        beat.last_of_run = 1'b1;
        run_cps.push_back(beat);
      end
      foreach (run_cps[i]) expected_cps.push_back(run_cps[i]);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(logic [CpW-1:0] cp, logic repl, logic last);
      cp_beat_t want;
      if (expected_cps.size() == 0) begin
        $error("code point %h arrived with nothing expected", cp);
        errors++;
        return;
      end
      want = expected_cps.pop_front();
      if (want.code_point != cp) begin
        $error("code_point: expected %h, got %h", want.code_point, cp);
        errors++;
      end
      if (want.is_replacement != repl) begin
        $error("is_replacement: expected %b, got %b", want.is_replacement, repl);
        errors++;
      end
      if (want.last_of_run != last) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_cps.size();
    endfunction
  endclass

endpackage

/* tb/utf8_stream_decoder_top_tb.sv */
// testbench top of the utf8 stream decoder: directed and random byte streams checked against a scoreboard
module utf8_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_tb_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandBytes  = 300;

  logic clk;
  logic rst_n;
  logic idle_on;
  logic hold_req;

  code_point_scoreboard sb;

  u8sd_in_if  in_ch();
  u8sd_out_if out_ch();

  utf8_stream_decoder_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one beat, with random idle cycles before it while idle_on is set, and wait for acceptance
  task automatic send_beat(input logic [7:0] b, input logic eot);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(b, eot);
  endtask

  // stop offering until every expected code point has come out
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // one sequence: mostly well-formed with random payload, some broken, some noise, some end of text
  task automatic send_random_seq(output int unsigned n_bytes);
    logic [7:0]  seq[4];
    int unsigned len;
    int unsigned cut;
    int unsigned pick;
    pick    = $urandom_range(99);
    n_bytes = 0;
    if (pick < 75) begin
      len = $urandom_range(1, 4);
      case (len)
        1: seq[0] = {1'b0, 7'($urandom)};
        2: seq[0] = {3'b110, 5'($urandom)};
        3: seq[0] = {4'b1110, 4'($urandom)};
        default: seq[0] = {5'b11110, 3'($urandom)};
      endcase
      for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
      cut = len;
      if (len > 1 && $urandom_range(99) < 25) cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++) begin
        send_beat(seq[i], 1'b0);
        n_bytes++;
      end
      // broken sequence: interrupting byte or end of text
      if (cut < len) begin
        if ($urandom_range(1) == 0) begin
          send_beat(8'($urandom), 1'b1);
        end else begin
          send_beat(8'($urandom), 1'b0);
          n_bytes++;
        end
      end
    end else if (pick < 93) begin
      send_beat(8'($urandom), 1'b0);
      n_bytes = 1;
    end else begin
      send_beat(8'($urandom), 1'b1);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= rst_n && (!idle_on || $urandom_range(99) >= 31);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.code_point, out_ch.is_replacement, out_ch.last_of_run);
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // main stimulus
  initial begin
    int unsigned sent;
    int unsigned n;
    logic        held;
    logic        paused;
    sb                = new();
    idle_on           = 1'b1;
    hold_req          = 1'b0;
    held              = 1'b0;
    paused            = 1'b0;
    sent              = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ascii, multi-byte extremes, decoded U+FFFD, bad bytes, flushes
    send_beat(8'h00, 1'b0);
    send_beat(8'hE2, 1'b0);
    send_beat(8'h82, 1'b0);
    send_beat(8'hAC, 1'b0);
    send_beat(8'hEF, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hBD, 1'b0);
    send_beat(8'hF7, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hF8, 1'b0);
    send_beat(8'hFF, 1'b0);
    // missing continuation after one taken, then ascii handled afresh
    send_beat(8'hE2, 1'b0);
    send_beat(8'h82, 1'b0);
    send_beat(8'h41, 1'b0);
    // missing continuation after two taken, offending byte opens a new lead
    send_beat(8'hF0, 1'b0);
    send_beat(8'h9F, 1'b0);
    send_beat(8'h98, 1'b0);
    send_beat(8'hF0, 1'b0);
    // end of text with a lead pending, then with nothing pending
    send_beat(8'hA5, 1'b1);
    send_beat(8'h5A, 1'b1);
    // lead replaced by another lead, which then completes
    send_beat(8'hC3, 1'b0);
    send_beat(8'hC3, 1'b0);
    send_beat(8'h80, 1'b0);
    drain_results();

    // random part
    while (sent < RandBytes) begin
      if (!held && sent >= 50) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      idle_on = !(sent >= 150 && sent < 230);
      if (!paused && sent >= 230) begin
        drain_results();
        paused = 1'b1;
      end
      send_random_seq(n);
      sent += n;
    end
    // close any open sequence so it is flushed
    send_beat(8'($urandom), 1'b1);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/u8sd_pkg.sv
rtl/u8sd_stream_if.sv
rtl/u8sd_decode.sv
rtl/u8sd_emit.sv
rtl/utf8_stream_decoder_top.sv
rtl/u8sd_checker.sv
tb/u8sd_tb_pkg.sv
tb/utf8_stream_decoder_top_tb.sv
